// ===== hdl/h3srt_pkg.sv =====
// ----------------------------------------------------------------------------
// h3srt_pkg
// shared types, constants and helpers of the http/3 stream role table
// ----------------------------------------------------------------------------
`default_nettype none

package h3srt_pkg;

    localparam int PUSH_DEPTH = 256;
    localparam int ID_W       = 62;
    localparam int FILL_W     = $clog2(PUSH_DEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int SLOTS      = 3;

    // stream type codes
    localparam logic [ID_W-1:0] TYPE_CONTROL = ID_W'(0);
    localparam logic [ID_W-1:0] TYPE_PUSH    = ID_W'(1);
    localparam logic [ID_W-1:0] TYPE_ENCODER = ID_W'(2);
    localparam logic [ID_W-1:0] TYPE_DECODER = ID_W'(3);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_CONTROL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ENCODER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_DECODER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MASK    = 2'd3;

    // slot indexes for peer and local ids
    localparam logic [1:0] SLOT_CONTROL = 2'd0;
    localparam logic [1:0] SLOT_ENCODER = 2'd1;
    localparam logic [1:0] SLOT_DECODER = 2'd2;

    typedef enum logic [2:0] {
        ROLE_REQUEST = 3'd0,
        ROLE_CONTROL = 3'd1,
        ROLE_PUSH    = 3'd2,
        ROLE_ENCODER = 3'd3,
        ROLE_DECODER = 3'd4,
        ROLE_UNKNOWN = 3'd5
    } t_role;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // lookup token walking the push cell row
    typedef struct packed {
        logic            valid;
        logic            hit;
        logic [ID_W-1:0] id;
    } t_token;

    function automatic t_role slot_role(input logic [1:0] k);
        t_role r;
        case (k)
            SLOT_CONTROL: r = ROLE_CONTROL;
            SLOT_ENCODER: r = ROLE_ENCODER;
            default:      r = ROLE_DECODER;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/h3srt_push_cell.sv =====
// ----------------------------------------------------------------------------
// h3srt_push_cell
// one push table entry plus one stage of the lookup token path
// ----------------------------------------------------------------------------
`default_nettype none

module h3srt_push_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic [h3srt_pkg::ID_W-1:0]     i_entry,
    output logic [h3srt_pkg::ID_W-1:0]     o_entry,
    input  logic                           i_occupied,
    input  h3srt_pkg::t_token              i_tok,
    output h3srt_pkg::t_token              o_tok
);
    import h3srt_pkg::*;

    logic [ID_W-1:0] r_entry;
    t_token          r_tok;
    t_token          n_tok;

    // appends shift the whole row by one entry
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    always_comb begin
        n_tok       = i_tok;
        n_tok.hit   = i_tok.hit | (i_occupied & (r_entry == i_tok.id));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule

`default_nettype wire

// ===== hdl/http3_stream_role_table.sv =====
// ----------------------------------------------------------------------------
// http3_stream_role_table
// map of quic stream ids to http/3 stream roles with a push table cell row
// ----------------------------------------------------------------------------
// usage:
//   command channel: an item transfers when i_start is high and o_busy is low.
//   i_mode 0 registers a peer stream type, i_mode 1 looks up a stream role.
//   each item gives one result on o_rejected / o_role / o_critical_ready,
//   shown for one cycle with o_done; the receiver cannot stall it.
//   config channel: i_cfg_valid with o_cfg_ready (always high) writes the
//   local ids and the local valid mask; write only while the block is idle.
// result path:
//   registrations, and lookups settled by the bidirectional bit, the peer
//   slots, the local ids or an empty push table: result shown in the cycle after start.
//   other lookups send a token down the row of PUSH_DEPTH push cells, one
//   cell per cycle: result registered once the token leaves the last cell,
//   with o_busy high meanwhile. the next item can transfer in the o_done cycle.
// reset:
//   synchronous active low; clears peer slot valid bits, the push fill count,
//   local registers and the token path. no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module http3_stream_role_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_mode,
    input  logic [h3srt_pkg::ID_W-1:0]        i_stream_id,
    input  logic [h3srt_pkg::ID_W-1:0]        i_stream_type,
    output logic                              o_done,
    output logic                              o_rejected,
    output logic [2:0]                        o_role,
    output logic                              o_critical_ready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [h3srt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [h3srt_pkg::ID_W-1:0]        i_cfg_data
);
    import h3srt_pkg::*;

    t_state             r_state, n_state;
    logic [ID_W-1:0]    r_peer_id [SLOTS];
    logic [SLOTS-1:0]   r_peer_valid, n_peer_valid;
    logic [SLOTS-1:0]   peer_wr;
    logic [ID_W-1:0]    r_local_id [SLOTS];
    logic [SLOTS-1:0]   r_local_mask;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               push_shift;

    logic               r_done, n_done;
    logic               r_rejected, n_rejected;
    t_role              r_role, n_role;
    logic               r_critical;

    logic               peer_hit, local_hit;
    t_role              peer_role, local_role;
    logic [1:0]         slot_sel;
    logic               slot_is_critical;
    logic               accept;

    t_token             inject;
    t_token             tok_chain [PUSH_DEPTH];
    logic [ID_W-1:0]    entry_chain [PUSH_DEPTH];
    t_token             tok_out;

    assign accept = i_start && (r_state == ST_IDLE);

    // peer slots win over local ids; lower slot wins within each group
    always_comb begin
        peer_hit   = 1'b0;
        peer_role  = ROLE_UNKNOWN;
        local_hit  = 1'b0;
        local_role = ROLE_UNKNOWN;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (r_peer_valid[k] && (r_peer_id[k] == i_stream_id)) begin
                peer_hit  = 1'b1;
                peer_role = slot_role(2'(k));
            end
            if (r_local_mask[k] && (r_local_id[k] == i_stream_id)) begin
                local_hit  = 1'b1;
                local_role = slot_role(2'(k));
            end
        end
    end

    always_comb begin
        slot_is_critical = 1'b1;
        slot_sel         = SLOT_CONTROL;
        case (i_stream_type)
            TYPE_CONTROL: slot_sel = SLOT_CONTROL;
            TYPE_ENCODER: slot_sel = SLOT_ENCODER;
            TYPE_DECODER: slot_sel = SLOT_DECODER;
            default:      slot_is_critical = 1'b0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_done       = 1'b0;
        n_rejected   = 1'b0;
        n_role       = ROLE_REQUEST;
        n_peer_valid = r_peer_valid;
        peer_wr      = '0;
        push_shift   = 1'b0;
        n_fill       = r_fill;
        inject       = '{valid: 1'b0, hit: 1'b0, id: i_stream_id};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!i_mode) begin
                        n_done = 1'b1;
                        if (!i_stream_id[1]) begin
                            n_rejected = 1'b1;
                        end else if (slot_is_critical) begin
                            if (r_peer_valid[slot_sel]) begin
                                n_rejected = 1'b1;
                            end else begin
                                peer_wr[slot_sel]      = 1'b1;
                                n_peer_valid[slot_sel] = 1'b1;
                            end
                        end else if (i_stream_type == TYPE_PUSH) begin
                            if (!i_stream_id[0] || (r_fill == FILL_W'(PUSH_DEPTH))) begin
                                n_rejected = 1'b1;
                            end else begin
                                push_shift = 1'b1;
                                n_fill     = r_fill + FILL_W'(1);
                            end
                        end
                    end else begin
                        if (!i_stream_id[1]) begin
                            n_done = 1'b1;
                            n_role = ROLE_REQUEST;
                        end else if (peer_hit) begin
                            n_done = 1'b1;
                            n_role = peer_role;
                        end else if (local_hit) begin
                            n_done = 1'b1;
                            n_role = local_role;
                        end else if (r_fill == '0) begin
                            n_done = 1'b1;
                            n_role = ROLE_UNKNOWN;
                        end else begin
                            inject.valid = 1'b1;
                            n_state      = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (tok_out.valid) begin
                    n_done  = 1'b1;
                    n_role  = tok_out.hit ? ROLE_PUSH : ROLE_UNKNOWN;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_peer_valid <= '0;
            r_fill       <= '0;
            r_done       <= 1'b0;
            r_rejected   <= 1'b0;
            r_role       <= ROLE_REQUEST;
            r_critical   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_peer_valid <= n_peer_valid;
            r_fill       <= n_fill;
            r_done       <= n_done;
            if (n_done) begin
                r_rejected <= n_rejected;
                r_role     <= n_role;
                r_critical <= &n_peer_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SLOTS; k++) begin
            if (peer_wr[k]) begin
                r_peer_id[k] <= i_stream_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_local_id[k] <= '0;
            end
            r_local_mask <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOCAL_CONTROL: r_local_id[SLOT_CONTROL] <= i_cfg_data;
                CFG_LOCAL_ENCODER: r_local_id[SLOT_ENCODER] <= i_cfg_data;
                CFG_LOCAL_DECODER: r_local_id[SLOT_DECODER] <= i_cfg_data;
                CFG_LOCAL_MASK:    r_local_mask <= i_cfg_data[SLOTS-1:0];
                default:           r_local_mask <= r_local_mask;
            endcase
        end
    end

    // push cell row: new ids enter at cell 0, the token walks toward the end
    for (genvar k = 0; k < PUSH_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign entry_chain[0] = i_stream_id;
        end
        if (k < PUSH_DEPTH - 1) begin : g_mid
            h3srt_push_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (push_shift),
                .i_entry    (entry_chain[k]),
                .o_entry    (entry_chain[k+1]),
                .i_occupied (r_fill > FILL_W'(k)),
                .i_tok      (tok_chain[k]),
                .o_tok      (tok_chain[k+1])
            );
        end else begin : g_tail
            h3srt_push_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_shift    (push_shift),
                .i_entry    (entry_chain[k]),
                .o_entry    (),
                .i_occupied (r_fill > FILL_W'(k)),
                .i_tok      (tok_chain[k]),
                .o_tok      (tok_out)
            );
        end
    end

    assign tok_chain[0] = inject;

    assign o_busy           = (r_state != ST_IDLE);
    assign o_done           = r_done;
    assign o_rejected       = r_rejected;
    assign o_role           = r_role;
    assign o_critical_ready = r_critical;
    assign o_cfg_ready      = 1'b1;

endmodule

`default_nettype wire

// ===== hdl/h3srt_checker.sv =====
// ----------------------------------------------------------------------------
// h3srt_checker
// port level checks of the stream role table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module h3srt_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       o_busy,
    input  logic       o_done,
    input  logic       o_rejected,
    input  logic [2:0] o_role
);
    import h3srt_pkg::*;

    // a result never shows while an item is still in flight
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_done && o_busy))
        else $error("result shown while busy");

    // every command transfer either finishes next cycle or starts a scan
    a_start_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_done || o_busy))
        else $error("command transfer lost");

    // a scan always ends with a result
    a_scan_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_done)
        else $error("scan ended without result");

    // a rejection only comes from a registration, whose role is request
    a_reject_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rejected) |-> (o_role == ROLE_REQUEST))
        else $error("rejected result with a lookup role");

endmodule

bind http3_stream_role_table h3srt_checker u_h3srt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .o_busy     (o_busy),
    .o_done     (o_done),
    .o_rejected (o_rejected),
    .o_role     (o_role)
);

`default_nettype wire

// ===== tb/sv/tb_http3_stream_role_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http3_stream_role_table
// self-checking bench for the http/3 stream role table: a short table of
// directed items, some with a fixed expected outcome, then random phases
// under several local id settings; other results are checked field by field
// against an in-bench copy of the stream map

module tb_http3_stream_role_table;
    import h3srt_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int LIMIT_CYCLES    = 1000000;
    localparam int NUM_PHASES      = 6;
    localparam int FLOOD_PHASE     = 2;
    localparam int ITEMS_PER_PHASE = 45;
    localparam int MAX_GAP         = 10;

    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_LOOKUP   = 1'b1;

    localparam logic [ID_W-1:0] ID_ALL_ONES = {ID_W{1'b1}};
    localparam logic [ID_W-1:0] ID_BIDI_MAX = ID_ALL_ONES & ~ID_W'(2);
    localparam logic [ID_W-1:0] TYPE_GREASE = ID_W'(33);

    typedef struct packed {
        logic  rejected;
        t_role role;
        logic  critical_ready;
    } t_outcome;

    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] item_id;
        logic [ID_W-1:0] item_type;
        logic            typed_in;
        t_outcome        outcome;
    } t_probe;

    localparam t_outcome NO_OUTCOME = '{1'b0, ROLE_REQUEST, 1'b0};

    // local ids at this point: control 0x2, encoder 0x6, decoder 0xf, all valid
    localparam int NUM_PROBES = 24;
    localparam t_probe PROBES [NUM_PROBES] = '{
        '{MODE_LOOKUP,   ID_W'(0),     ID_W'(0),     1'b1, '{1'b0, ROLE_REQUEST, 1'b0}},
        '{MODE_LOOKUP,   ID_ALL_ONES,  ID_ALL_ONES,  1'b1, '{1'b0, ROLE_UNKNOWN, 1'b0}},
        '{MODE_LOOKUP,   ID_W'('h2),   ID_W'(0),     1'b0, NO_OUTCOME},
        // bidirectional id cannot be registered
        '{MODE_REGISTER, ID_W'('h4),   TYPE_CONTROL, 1'b1, '{1'b1, ROLE_REQUEST, 1'b0}},
        '{MODE_REGISTER, ID_W'('h3),   TYPE_CONTROL, 1'b0, NO_OUTCOME},
        '{MODE_REGISTER, ID_W'('h7),   TYPE_CONTROL, 1'b1, '{1'b1, ROLE_REQUEST, 1'b0}},
        '{MODE_LOOKUP,   ID_W'('h7),   ID_W'(0),     1'b0, NO_OUTCOME},
        // peer decoder on the local encoder id: peer slot must win
        '{MODE_REGISTER, ID_W'('h6),   TYPE_DECODER, 1'b0, NO_OUTCOME},
        '{MODE_LOOKUP,   ID_W'('h6),   ID_W'(0),     1'b0, NO_OUTCOME},
        // push from a client-initiated id
        '{MODE_REGISTER, ID_W'('h2),   TYPE_PUSH,    1'b1, '{1'b1, ROLE_REQUEST, 1'b0}},
        '{MODE_REGISTER, ID_W'('hb),   TYPE_PUSH,    1'b0, NO_OUTCOME},
        '{MODE_REGISTER, ID_W'('hb),   TYPE_PUSH,    1'b0, NO_OUTCOME},
        // push on the local decoder id: local must win
        '{MODE_REGISTER, ID_W'('hf),   TYPE_PUSH,    1'b0, NO_OUTCOME},
        '{MODE_LOOKUP,   ID_W'('hf),   ID_W'(0),     1'b0, NO_OUTCOME},
        '{MODE_LOOKUP,   ID_W'('hb),   ID_W'(0),     1'b0, NO_OUTCOME},
        '{MODE_REGISTER, ID_ALL_ONES,  ID_ALL_ONES,  1'b1, '{1'b0, ROLE_REQUEST, 1'b0}},
        '{MODE_REGISTER, ID_W'('h13),  TYPE_GREASE,  1'b1, '{1'b0, ROLE_REQUEST, 1'b0}},
        '{MODE_REGISTER, ID_W'('he),   TYPE_ENCODER, 1'b0, NO_OUTCOME},
        '{MODE_REGISTER, ID_W'('h12),  TYPE_ENCODER, 1'b1, '{1'b1, ROLE_REQUEST, 1'b1}},
        '{MODE_REGISTER, ID_ALL_ONES,  TYPE_DECODER, 1'b1, '{1'b1, ROLE_REQUEST, 1'b1}},
        '{MODE_LOOKUP,   ID_W'('h3),   ID_W'(0),     1'b0, NO_OUTCOME},
        '{MODE_LOOKUP,   ID_BIDI_MAX,  ID_ALL_ONES,  1'b1, '{1'b0, ROLE_REQUEST, 1'b1}},
        '{MODE_REGISTER, ID_W'(0),     ID_W'(0),     1'b1, '{1'b1, ROLE_REQUEST, 1'b1}},
        '{MODE_LOOKUP,   ID_W'('he),   ID_W'(0),     1'b0, NO_OUTCOME}
    };

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_start       = 1'b0;
    logic                 i_mode        = 1'b0;
    logic [ID_W-1:0]      i_stream_id   = '0;
    logic [ID_W-1:0]      i_stream_type = '0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [ID_W-1:0]      i_cfg_data    = '0;
    logic                 o_busy;
    logic                 o_done;
    logic                 o_rejected;
    logic [2:0]           o_role;
    logic                 o_critical_ready;
    logic                 o_cfg_ready;

    // in-bench copy of the stream map
    logic [ID_W-1:0]  local_ids [SLOTS];
    logic [SLOTS-1:0] local_mask;
    logic [ID_W-1:0]  peer_ids [SLOTS];
    logic [SLOTS-1:0] peer_seen = '0;
    logic [ID_W-1:0]  pushed_list [PUSH_DEPTH];
    int               pushed_used = 0;
    t_role            slot_roles [SLOTS] = '{ROLE_CONTROL, ROLE_ENCODER, ROLE_DECODER};

    t_outcome        outcomes_due [$];
    logic [ID_W-1:0] seen_ids [$];
    int              max_gap        = MAX_GAP;
    int              mismatch_count = 0;
    int              results_seen   = 0;

    http3_stream_role_table u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_mode           (i_mode),
        .i_stream_id      (i_stream_id),
        .i_stream_type    (i_stream_type),
        .o_done           (o_done),
        .o_rejected       (o_rejected),
        .o_role           (o_role),
        .o_critical_ready (o_critical_ready),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", outcomes_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [ID_W-1:0] random_id();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ID_W-1:0];
    endfunction

    // applies one item to the stream map and returns its outcome
    function automatic t_outcome map_stream_item(input logic mode, input logic [ID_W-1:0] id,
                                                 input logic [ID_W-1:0] typ);
        t_outcome res;
        int       k;
        logic     found;
        res   = NO_OUTCOME;
        found = 1'b0;
        if (mode == MODE_REGISTER) begin
            if (!id[1]) begin
                res.rejected = 1'b1;
            end else if (typ == TYPE_CONTROL || typ == TYPE_ENCODER || typ == TYPE_DECODER) begin
                k = (typ == TYPE_CONTROL) ? int'(SLOT_CONTROL) :
                    (typ == TYPE_ENCODER) ? int'(SLOT_ENCODER) : int'(SLOT_DECODER);
                if (peer_seen[k]) begin
                    res.rejected = 1'b1;
                end else begin
                    peer_ids[k]  = id;
                    peer_seen[k] = 1'b1;
                end
            end else if (typ == TYPE_PUSH) begin
                if (!id[0] || pushed_used >= PUSH_DEPTH) begin
                    res.rejected = 1'b1;
                end else begin
                    pushed_list[pushed_used] = id;
                    pushed_used++;
                end
            end
        end else if (id[1]) begin
            res.role = ROLE_UNKNOWN;
            for (k = 0; k < SLOTS; k++) begin
                if (!found && peer_seen[k] && peer_ids[k] == id) begin
                    res.role = slot_roles[k];
                    found    = 1'b1;
                end
            end
            for (k = 0; k < SLOTS; k++) begin
                if (!found && local_mask[k] && local_ids[k] == id) begin
                    res.role = slot_roles[k];
                    found    = 1'b1;
                end
            end
            for (k = 0; k < pushed_used; k++) begin
                if (!found && pushed_list[k] == id) begin
                    res.role = ROLE_PUSH;
                    found    = 1'b1;
                end
            end
        end
        res.critical_ready = &peer_seen;
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (outcomes_due.size() == 0) begin
                flag_mismatch($sformatf("result %0d with no item outstanding", results_seen));
            end else begin
                want = outcomes_due.pop_front();
                if (o_rejected !== want.rejected)
                    flag_mismatch($sformatf("result %0d rejected %b, want %b",
                                            results_seen, o_rejected, want.rejected));
                if (o_role !== want.role)
                    flag_mismatch($sformatf("result %0d role %0d, want %0d",
                                            results_seen, o_role, want.role));
                if (o_critical_ready !== want.critical_ready)
                    flag_mismatch($sformatf("result %0d critical_ready %b, want %b",
                                            results_seen, o_critical_ready,
                                            want.critical_ready));
            end
            results_seen++;
        end
    end

    // one command transfer; start stays high when the next item follows at once
    task automatic issue_item(input logic mode, input logic [ID_W-1:0] id,
                              input logic [ID_W-1:0] typ, input logic typed_in,
                              input t_outcome typed_outcome);
        int       gap;
        t_outcome due;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_mode        <= mode;
        i_stream_id   <= id;
        i_stream_type <= typ;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        due = map_stream_item(mode, id, typ);
        if (typed_in) due = typed_outcome;
        outcomes_due.push_back(due);
        if (mode == MODE_REGISTER) seen_ids.push_back(id);
    endtask

    task automatic hold_until_drained();
        i_start <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes; caller lowers it
    task automatic put_local_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_LOCAL_CONTROL: local_ids[SLOT_CONTROL] = data;
            CFG_LOCAL_ENCODER: local_ids[SLOT_ENCODER] = data;
            CFG_LOCAL_DECODER: local_ids[SLOT_DECODER] = data;
            default:           local_mask = data[SLOTS-1:0];
        endcase
    endtask

    task automatic load_local_regs(input logic [ID_W-1:0] ctl, input logic [ID_W-1:0] enc,
                                   input logic [ID_W-1:0] dec, input logic [ID_W-1:0] mask);
        put_local_reg(CFG_LOCAL_CONTROL, ctl);
        put_local_reg(CFG_LOCAL_ENCODER, enc);
        put_local_reg(CFG_LOCAL_DECODER, dec);
        put_local_reg(CFG_LOCAL_MASK, mask);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic draw_stream_item(input int push_pct, output logic mode,
                                    output logic [ID_W-1:0] id, output logic [ID_W-1:0] typ);
        int pick;
        int share;
        pick = $urandom_range(0, 99);
        mode = MODE_REGISTER;
        id   = random_id();
        typ  = random_id();
        if (pick < push_pct) begin
            typ = TYPE_PUSH;
            case ($urandom_range(0, 7))
                0: if (pushed_used > 0) id = pushed_list[$urandom_range(0, pushed_used - 1)];
                1: id = local_ids[$urandom_range(0, SLOTS - 1)] | ID_W'(3);
                2: id[1:0] = 2'b10;
                default: id[1:0] = 2'b11;
            endcase
        end else begin
            share = (pick - push_pct) * 100 / (100 - push_pct);
            if (share < 55) begin
                mode = MODE_LOOKUP;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: if (seen_ids.size() > 0)
                        id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
                    4: id = local_ids[$urandom_range(0, SLOTS - 1)];
                    5: if (pushed_used > 0)
                        id = pushed_list[$urandom_range(0, pushed_used - 1)];
                    6: id = peer_ids[$urandom_range(0, SLOTS - 1)];
                    7: id[1] = 1'b0;
                    default: id[1] = 1'b1;
                endcase
            end else if (share < 67) begin
                // late claims of the critical slots
                case ($urandom_range(0, 2))
                    0: typ = TYPE_CONTROL;
                    1: typ = TYPE_ENCODER;
                    default: typ = TYPE_DECODER;
                endcase
            end else if (share < 85) begin
                case ($urandom_range(0, 2))
                    0: typ = ID_W'(64'h1f * $urandom + 64'h21);
                    1: typ = ID_W'($urandom_range(4, 63));
                    default: ;
                endcase
                id[1] = ($urandom_range(0, 3) != 0);
            end else begin
                mode = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 0) typ = ID_W'($urandom_range(0, 3));
            end
        end
    endtask

    initial begin
        int              r;
        int              ph;
        int              sent;
        logic            mode;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] typ;
        logic [ID_W-1:0] cfg_ctl;
        logic [ID_W-1:0] cfg_enc;
        logic [ID_W-1:0] cfg_dec;
        logic [ID_W-1:0] cfg_mask;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_local_regs(ID_W'('h2), ID_W'('h6), ID_W'('hf), ID_W'(7));
        for (r = 0; r < NUM_PROBES; r++)
            issue_item(PROBES[r].mode, PROBES[r].item_id, PROBES[r].item_type,
                       PROBES[r].typed_in, PROBES[r].outcome);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            hold_until_drained();
            case (ph)
                0: begin
                    cfg_ctl = '0; cfg_enc = '0; cfg_dec = '0; cfg_mask = '0;
                end
                1: begin
                    cfg_ctl = '1; cfg_enc = '1; cfg_dec = '1; cfg_mask = '1;
                end
                3: begin
                    cfg_ctl  = random_id();
                    cfg_enc  = random_id();
                    cfg_dec  = random_id();
                    cfg_mask = random_id();
                end
                4: begin
                    // local ids that shadow a peer slot and a push entry
                    cfg_ctl  = peer_ids[SLOT_ENCODER];
                    cfg_enc  = (pushed_used > 0)
                             ? pushed_list[$urandom_range(0, pushed_used - 1)]
                             : random_id();
                    cfg_dec  = random_id() | ID_W'(2);
                    cfg_mask = ID_W'($urandom_range(0, 7));
                end
                default: begin
                    cfg_ctl  = random_id() | ID_W'(3);
                    cfg_enc  = random_id() | ID_W'(3);
                    cfg_dec  = random_id() | ID_W'(2);
                    cfg_mask = ID_W'($urandom_range(1, 7));
                end
            endcase
            load_local_regs(cfg_ctl, cfg_enc, cfg_dec, cfg_mask);

            sent = 0;
            // the flood phase keeps going until the push table is full
            while (sent < ITEMS_PER_PHASE || (ph == FLOOD_PHASE && pushed_used < PUSH_DEPTH)) begin
                if (sent % 16 == 0) max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
                if ($urandom_range(0, 39) == 0) hold_until_drained();
                draw_stream_item((ph == FLOOD_PHASE) ? 85 : 30, mode, id, typ);
                issue_item(mode, id, typ, 1'b0, NO_OUTCOME);
                sent++;
            end
        end

        hold_until_drained();
        repeat (PUSH_DEPTH + 8) @(posedge i_clk);
        if (outcomes_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", outcomes_due.size()));
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
